FILE: sv/ffla_pkg.sv
package ffla_pkg;

  // Default sizing
  localparam int NUM_POOLS_DEF  = 2;
  localparam int POOL_BYTES_DEF = 2097152;
  localparam int LIST_DEPTH_DEF = 16;

  // Field widths
  localparam int LEN_W = 22;
  localparam int OFF_W = 21;
  localparam int STS_W = 2;

  // Stream packing
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_t;

endpackage

FILE: sv/ffla_ram.sv
module ffla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/first_fit_free_list_allocator.sv
// First-fit free-list allocator for a set of byte pools.
// Input beats on s_axis carry one request each: tuser selects the operation
// (allocate or release) and the pool; tdata carries the size and, for a
// release, the block offset. Each request yields exactly one result beat on
// m_axis with a status code and, for a successful allocate, the block offset.
// The extent lists of all pools live in one RAM with a registered read.
// A request walks its pool's list one entry per cycle, at most LIST_DEPTH
// entries; the RAM read register lies between the read of an entry and
// its check, the write-back happens in the cycle the walk ends, and then
// the result moves to the output register once that register is free.
// One request is in flight at a time, so a new request is accepted only
// once the last one has handed its result to the output register.
// s_axis_tready is high while the block is idle, even while a finished result
// still waits in the output register; a stalled m_axis holds that result,
// and the next request still walks its list and then waits to hand over its result.
// After reset every pool holds one extent covering the whole pool; entry 0
// of each pool reads as that extent until first written, so no clearing
// pass is needed and the block accepts a request in the first cycle.
module first_fit_free_list_allocator
  import ffla_pkg::*;
#(
  parameter int NUM_POOLS  = NUM_POOLS_DEF,
  parameter int POOL_BYTES = POOL_BYTES_DEF,
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [21:0] request_size, [42:22] release_offset, [47:43] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation, [1] page
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] status, [22:2] block_offset, [23] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int EW = 2 * LEN_W;
  localparam int RAM_DEPTH = 2 ** (PW + IW);
  localparam logic [LEN_W-1:0] POOL_LEN = LEN_W'(POOL_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

  state_t state, state_next;

  // Request registers
  op_t              op_r;
  logic [PW-1:0]    pg_r;
  logic [LEN_W-1:0] size_r;
  logic [OFF_W-1:0] roff_r;
  logic [CW-1:0]    n_r;

  // Walk control
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] chk_idx;
  logic          chk_valid;

  // Per-pool list state
  logic [CW-1:0] ext_count [NUM_POOLS];
  logic          init0 [NUM_POOLS];

  // Result
  status_t          res_status, res_status_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  logic             out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // RAM ports
  logic              ram_we, ram_re;
  logic [PW+IW-1:0]  ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  logic          s_beat;
  logic [PW-1:0] pg_in;
  logic          done, cnt_inc;

  logic [LEN_W-1:0] ent_start, ent_len;
  logic             alloc_hit, rel_hit, hit, last;
  logic [LEN_W:0]   rel_end, len_sum;
  logic [LEN_W-1:0] merge_len;

  assign s_beat = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Saturate the pool index
  always_comb begin
    if (32'(s_axis_tuser[1]) >= NUM_POOLS) begin
      pg_in = PW'(NUM_POOLS - 1);
    end else begin
      pg_in = PW'(s_axis_tuser[1]);
    end
  end

  ffla_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry under test; entry 0 reads as the whole pool until first written
  always_comb begin
    if (chk_idx[IW-1:0] == '0 && !init0[pg_r]) begin
      ent_start = '0;
      ent_len   = POOL_LEN;
    end else begin
      ent_start = ram_rdata[LEN_W-1:0];
      ent_len   = ram_rdata[EW-1:LEN_W];
    end
  end

  // Fit and merge checks
  always_comb begin
    rel_end   = {2'b00, roff_r} + {1'b0, size_r};
    len_sum   = {1'b0, ent_len} + {1'b0, size_r};
    merge_len = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    alloc_hit = size_r < ent_len;
    rel_hit   = ({1'b0, ent_start} == rel_end);
    hit       = chk_valid && ((op_r == OP_ALLOC) ? alloc_hit : rel_hit);
    if (chk_valid) begin
      last = (CW'(chk_idx + 1'b1) == n_r);
    end else begin
      last = (rd_idx >= n_r);
    end
  end

  // Next state, RAM access and result
  always_comb begin
    state_next      = state;
    ram_re          = 1'b0;
    ram_raddr       = {pg_r, rd_idx[IW-1:0]};
    ram_we          = 1'b0;
    ram_waddr       = {pg_r, chk_idx[IW-1:0]};
    ram_wdata       = '0;
    done            = 1'b0;
    cnt_inc         = 1'b0;
    res_status_next = res_status;
    res_off_next    = res_off;
    case (state)
      S_IDLE: begin
        if (s_beat) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re = (rd_idx < n_r);
        if (hit) begin
          ram_we = 1'b1;
          done   = 1'b1;
          res_status_next = ST_OK;
          if (op_r == OP_ALLOC) begin
            ram_wdata    = {LEN_W'(ent_len - size_r), LEN_W'(ent_start + size_r)};
            res_off_next = ent_start[OFF_W-1:0];
          end else begin
            ram_wdata    = {merge_len, {1'b0, roff_r}};
            res_off_next = '0;
          end
        end else if (last) begin
          done         = 1'b1;
          res_off_next = '0;
          if (op_r == OP_ALLOC) begin
            res_status_next = ST_NO_FIT;
          end else if (n_r >= CW'(LIST_DEPTH)) begin
            res_status_next = ST_FULL;
          end else begin
            // Append a new extent at the tail
            ram_we          = 1'b1;
            ram_waddr       = {pg_r, n_r[IW-1:0]};
            ram_wdata       = {size_r, {1'b0, roff_r}};
            cnt_inc         = 1'b1;
            res_status_next = ST_OK;
          end
        end
        if (done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (s_beat) begin
      chk_valid <= 1'b0;
    end else if (state == S_SCAN) begin
      chk_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      op_r   <= op_t'(s_axis_tuser[0]);
      pg_r   <= pg_in;
      size_r <= s_axis_tdata[LEN_W-1:0];
      roff_r <= s_axis_tdata[LEN_W+OFF_W-1:LEN_W];
      n_r    <= ext_count[pg_in];
      rd_idx <= '0;
    end else if (state == S_SCAN) begin
      chk_idx <= rd_idx;
      if (ram_re) begin
        rd_idx <= CW'(rd_idx + 1'b1);
      end
    end
    if (done) begin
      res_status <= res_status_next;
      res_off    <= res_off_next;
    end
  end

  // Extent counts and entry 0 written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        ext_count[p] <= CW'(1);
        init0[p]     <= 1'b0;
      end
    end else begin
      if (cnt_inc) begin
        ext_count[pg_r] <= CW'(n_r + 1'b1);
      end
      if (ram_we && ram_waddr[IW-1:0] == '0) begin
        init0[pg_r] <= 1'b1;
      end
    end
  end

  // Output register: hold while stalled, load the result when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || m_axis_tready)) begin
      out_data <= {1'b0, res_off, res_status};
    end
  end

endmodule

FILE: sv/ffla_checker.sv
module ffla_checker
  import ffla_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Status is one of the defined codes
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_NO_FIT ||
                       m_axis_tdata[1:0] == ST_FULL))
    else $error("undefined status code");

  // A failed request carries a zero offset
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[22:2] == '0)
    else $error("nonzero offset on failure");

  // One request in flight: a beat closes the input while its request is in flight
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted during a walk");

  // The block is ready right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

endmodule

bind first_fit_free_list_allocator ffla_checker u_ffla_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/testbench.sv
module testbench;
  import ffla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOOL = NUM_POOLS_DEF;
  localparam int DEPTH = LIST_DEPTH_DEF;
  localparam int POOL = POOL_BYTES_DEF;
  localparam int OFF_MAX = (1 << OFF_W) - 1;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam int PAD_W = IN_DATA_W - OFF_W - LEN_W;

  // Two copies of the free lists: one steers stimulus, one checks results
  localparam int GEN_VIEW = 0;
  localparam int CHK_VIEW = 1;

  localparam int RANDOM_REQUESTS = 1720;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic              drain;
    op_t               op;
    logic              pg;
    logic [LEN_W-1:0]  size;
    logic [OFF_W-1:0]  roff;
  } request_t;

  typedef struct packed {
    status_t           sts;
    logic [OFF_W-1:0]  boff;
  } outcome_t;

  typedef struct packed {
    logic              pg;
    logic [LEN_W-1:0]  size;
    logic [OFF_W-1:0]  off;
  } live_block_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [LEN_W-1:0] ext_start [2][NPOOL][DEPTH];
  logic [LEN_W-1:0] ext_len   [2][NPOOL][DEPTH];
  int               ext_cnt   [2][NPOOL];

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  live_block_t live_q [$];

  logic in_fire = 1'b0;
  int   errors = 0;
  int   results_seen = 0;
  int   n_ok = 0;
  int   n_no_fit = 0;
  int   n_full = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   rx_cycle = 0;
  int   stall_mode = 0;
  int   hold_left = 0;
  int   holds_done = 0;

  first_fit_free_list_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // [21:0] request_size, [42:22] release_offset, [47:43] zero
    .s_axis_tdata  (s_axis_tdata),
    // [0] operation, [1] page
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [1:0] status, [22:2] block_offset, [23] zero
    .m_axis_tdata  (m_axis_tdata)
  );

  // Put one copy of the lists in its post-reset state
  function automatic void clear_lists(input int view);
    for (int p = 0; p < NPOOL; p++) begin
      for (int i = 0; i < DEPTH; i++) begin
        ext_start[view][p][i] = '0;
        ext_len[view][p][i] = '0;
      end
      ext_len[view][p][0] = POOL[LEN_W-1:0];
      ext_cnt[view][p] = 1;
    end
  endfunction

  // First-fit allocate or merge/append release on one copy of the lists
  function automatic void walk_free_list(input int view, input op_t op, input logic pg,
                                         input logic [LEN_W-1:0] size,
                                         input logic [OFF_W-1:0] roff,
                                         output status_t sts, output logic [OFF_W-1:0] boff);
    int         p;
    int         n;
    logic       done;
    logic [LEN_W:0] blk_end;
    logic [LEN_W:0] grown;
    p = (int'(pg) >= NPOOL) ? NPOOL - 1 : int'(pg);
    n = (ext_cnt[view][p] > DEPTH) ? DEPTH : ext_cnt[view][p];
    sts = ST_NO_FIT;
    boff = '0;
    done = 1'b0;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < n; i++) begin
        if (!done && size < ext_len[view][p][i]) begin
          boff = ext_start[view][p][i][OFF_W-1:0];
          ext_start[view][p][i] = ext_start[view][p][i] + size;
          ext_len[view][p][i] = ext_len[view][p][i] - size;
          sts = ST_OK;
          done = 1'b1;
        end
      end
    end else begin
      // compare the block end at full width, no wrap
      blk_end = {2'b00, roff} + {1'b0, size};
      for (int i = 0; i < n; i++) begin
        if (!done && {1'b0, ext_start[view][p][i]} == blk_end) begin
          grown = {1'b0, ext_len[view][p][i]} + {1'b0, size};
          ext_len[view][p][i] = grown[LEN_W] ? LEN_MAX : grown[LEN_W-1:0];
          ext_start[view][p][i] = {1'b0, roff};
          done = 1'b1;
        end
      end
      if (done) begin
        sts = ST_OK;
      end else if (n >= DEPTH) begin
        sts = ST_FULL;
      end else begin
        ext_start[view][p][n] = {1'b0, roff};
        ext_len[view][p][n] = size;
        ext_cnt[view][p] = n + 1;
        sts = ST_OK;
      end
    end
  endfunction

  // Queue one request and advance the stimulus view of the lists
  task automatic queue_request(input op_t op, input logic pg, input logic [LEN_W-1:0] size,
                               input logic [OFF_W-1:0] roff, input logic drain,
                               output status_t sts, output logic [OFF_W-1:0] boff);
    request_t req;
    walk_free_list(GEN_VIEW, op, pg, size, roff, sts, boff);
    req.drain = drain;
    req.op = op;
    req.pg = pg;
    req.size = size;
    req.roff = roff;
    request_q.push_back(req);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus plan, reset and end of run
  initial begin
    status_t          sts;
    logic [OFF_W-1:0] boff;
    live_block_t      blk;
    int               r;
    int               k;
    logic             drain;
    logic [LEN_W-1:0] size;

    clear_lists(GEN_VIEW);
    clear_lists(CHK_VIEW);

    // Directed: zero-size allocate, no fit at full pool, extremes, merges
    queue_request(OP_ALLOC, 1'b0, 0, 0, 1'b0, sts, boff);
    queue_request(OP_ALLOC, 1'b0, LEN_W'(POOL), 0, 1'b0, sts, boff);
    queue_request(OP_ALLOC, 1'b1, LEN_W'(POOL - 1), 0, 1'b0, sts, boff);
    queue_request(OP_RELEASE, 1'b1, LEN_W'(POOL - 1), 0, 1'b0, sts, boff);
    queue_request(OP_ALLOC, 1'b0, 1000, 0, 1'b0, sts, boff);
    queue_request(OP_ALLOC, 1'b0, 24, 0, 1'b0, sts, boff);
    queue_request(OP_RELEASE, 1'b0, 24, 1000, 1'b0, sts, boff);
    queue_request(OP_RELEASE, 1'b0, 1000, 0, 1'b0, sts, boff);
    // append at the top offset with the pool size, then a zero-size merge
    queue_request(OP_RELEASE, 1'b0, LEN_W'(POOL), OFF_W'(OFF_MAX), 1'b0, sts, boff);
    queue_request(OP_RELEASE, 1'b0, 0, 0, 1'b0, sts, boff);
    // fill page 1 with empty extents until the list is full
    for (k = 1; k < DEPTH; k++)
      queue_request(OP_RELEASE, 1'b1, 0, OFF_W'(k * 10), 1'b0, sts, boff);
    queue_request(OP_RELEASE, 1'b1, 5, 500, 1'b0, sts, boff);
    queue_request(OP_ALLOC, 1'b1, 0, 0, 1'b0, sts, boff);

    // Random: mostly allocate/release pairs in stack order, some noise
    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      drain = (k == 0 || k == 600 || k == 1200);
      r = $urandom_range(0, 99);
      if (live_q.size() > 0 && (r >= 45 && r < 82 || live_q.size() >= 32)) begin
        blk = live_q.pop_back();
        queue_request(OP_RELEASE, blk.pg, blk.size, blk.off, drain, sts, boff);
      end else if (r < 82) begin
        r = $urandom_range(0, 99);
        if (r < 5) size = 0;
        else if (r < 8) size = LEN_W'(POOL);
        else if (r < 20) size = LEN_W'($urandom_range(0, POOL));
        else size = LEN_W'($urandom_range(1, 4096));
        blk.pg = 1'($urandom_range(0, 1));
        queue_request(OP_ALLOC, blk.pg, size, OFF_W'($urandom), drain, sts, boff);
        if (sts == ST_OK) begin
          blk.size = size;
          blk.off = boff;
          live_q.push_back(blk);
        end
      end else begin
        size = ($urandom_range(0, 1) == 1) ? LEN_W'($urandom_range(0, 4096))
                                           : LEN_W'($urandom_range(0, POOL));
        queue_request(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), size,
                      OFF_W'($urandom_range(0, OFF_MAX)), drain, sts, boff);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (request_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("checked %0d results: %0d ok, %0d no fit, %0d list full", results_seen, n_ok,
             n_no_fit, n_full);
    $display("receiver hold-offs: %0d, random stalls and sender bursts throughout",
             holds_done);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $error("timeout with %0d requests queued, %0d results outstanding", request_q.size(),
           outcome_q.size());
    $display("testbench: errors");
    $finish;
  end

  // Offer requests in bursts; hold a beat until taken; pause for drains
  always @(negedge clk) begin : drive_requests
    request_t req;
    if (!rst) begin
      if (in_fire) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end
      if (!(s_axis_tvalid && !in_fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() > 0 && !(request_q[0].drain && outcome_q.size() != 0)) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          req = request_q[0];
          s_axis_tdata <= {{PAD_W{1'b0}}, req.roff, req.size};
          s_axis_tuser <= {req.pg, req.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side on a changing pattern, with long hold-offs
  always @(negedge clk) begin : drive_ready
    if (!rst) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 250 : 1100)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            m_axis_tready <= (rx_cycle % 9 >= 4);
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 19) != 0);
          end
        endcase
      end
    end
  end

  // Check each result beat, then predict each accepted request beat
  always @(posedge clk) begin : track_beats
    status_t          sts;
    logic [OFF_W-1:0] boff;
    outcome_t         want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $error("result beat with no request outstanding: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          case (want.sts)
            ST_OK: n_ok++;
            ST_NO_FIT: n_no_fit++;
            default: n_full++;
          endcase
          if (m_axis_tdata[STS_W-1:0] !== want.sts) begin
            $error("status: expected %0d, got %0d", want.sts, m_axis_tdata[STS_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[STS_W +: OFF_W] !== want.boff) begin
            $error("block_offset: expected %0d, got %0d", want.boff,
                   m_axis_tdata[STS_W +: OFF_W]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        walk_free_list(CHK_VIEW, op_t'(s_axis_tuser[0]), s_axis_tuser[1],
                       s_axis_tdata[LEN_W-1:0], s_axis_tdata[LEN_W +: OFF_W], sts, boff);
        want.sts = sts;
        want.boff = boff;
        outcome_q.push_back(want);
        if (request_q.size() > 0) void'(request_q.pop_front());
      end
    end
  end

endmodule

FILE: filelist.f
sv/ffla_pkg.sv
sv/ffla_ram.sv
sv/first_fit_free_list_allocator.sv
sv/ffla_checker.sv
sim/testbench.sv
